// ===== rtl/core/smre_pkg.sv =====
// Shared types and constants of the static-model range encoder.
package smre_pkg;

    localparam int RANGE_PRECISION = 14;
    localparam int CODER_W = 64;
    localparam int BYTE_W = 8;
    localparam int TABLE_W = 15;
    localparam int TABLE_DEPTH = 258;
    localparam int SYM_W = 9;
    localparam int CMD_W = 2;
    localparam int INIT_LOW_W = 63;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W = 4;
    localparam int RENORM_BYTES = 3;
    localparam int RENORM_SHIFT = 24;
    localparam int FLUSH_SCAN_BYTES = 7;

    localparam logic [CODER_W-1:0] RENORM_LIMIT = CODER_W'(1) << (33 - RANGE_PRECISION);
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_LOW   = 1'b0,
        REG_INITIAL_RANGE = 1'b1
    } cfg_reg_t;

    // Results of one item: an optional leading carry, a run of bytes taken from
    // the top of word, and an optional trailing carry.
    typedef struct packed {
        logic               lead_carry;
        logic               trail_carry;
        logic [CNT_W-1:0]   byte_count;
        logic [CODER_W-1:0] word;
    } emit_load_t;

endpackage

// ===== rtl/core/smre_ifs.sv =====
// Channel interfaces of the static-model range encoder.
interface smre_in_if;
    logic                                valid;
    logic                                ready;
    logic [smre_pkg::CMD_W-1:0]          command;
    logic [smre_pkg::SYM_W-1:0]          table_index;
    logic [smre_pkg::TABLE_W-1:0]        table_value;
    logic [smre_pkg::BYTE_W-1:0]         data_byte;

    modport source (output valid, command, table_index, table_value, data_byte, input ready);
    modport sink (input valid, command, table_index, table_value, data_byte, output ready);
endinterface

interface smre_out_if;
    logic                                valid;
    logic                                ready;
    logic [smre_pkg::BYTE_W-1:0]         out_byte;
    logic                                is_carry;
    logic                                last;

    modport source (output valid, out_byte, is_carry, last, input ready);
    modport sink (input valid, out_byte, is_carry, last, output ready);
endinterface

interface smre_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [smre_pkg::CFG_IDX_W-1:0]      index;
    logic [smre_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/smre_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module smre_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 258
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_a_reg <= mem_reg[rd_addr_a];
            rd_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== rtl/core/smre_emit.sv =====
// Result sequencer: sends the carry and byte results of one item, one per transfer.
module smre_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    input  smre_pkg::emit_load_t load,
    output logic                 free,
    smre_out_if.source           result
);

    logic                                pend_valid_reg, pend_valid_next;
    logic                                lead_reg, lead_next;
    logic                                trail_reg, trail_next;
    logic [smre_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [smre_pkg::CODER_W-1:0]        word_reg, word_next;
    logic [smre_pkg::BYTE_W-1:0]         cur_byte;
    logic                                cur_carry;
    logic                                cur_last;
    logic                                take;

    always_comb
    begin
        cur_byte = '0;
        cur_carry = 1'b1;
        cur_last = 1'b1;
        if (lead_reg)
        begin
            cur_last = (count_reg == '0) && !trail_reg;
        end
        else if (count_reg != '0)
        begin
            cur_byte = word_reg[smre_pkg::CODER_W-1 -: smre_pkg::BYTE_W];
            cur_carry = 1'b0;
            cur_last = (count_reg == smre_pkg::CNT_W'(1)) && !trail_reg;
        end
    end

    assign take = pend_valid_reg && result.ready;
    assign free = !pend_valid_reg || (result.ready && cur_last);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        lead_next = lead_reg;
        trail_next = trail_reg;
        count_next = count_reg;
        word_next = word_reg;
        if (take)
        begin
            if (lead_reg)
            begin
                lead_next = 1'b0;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - smre_pkg::CNT_W'(1);
                word_next = word_reg << smre_pkg::BYTE_W;
            end
            else
            begin
                trail_next = 1'b0;
            end
            if (cur_last)
            begin
                pend_valid_next = 1'b0;
            end
        end
        if (load_valid && free)
        begin
            pend_valid_next = 1'b1;
            lead_next = load.lead_carry;
            trail_next = load.trail_carry;
            count_next = load.byte_count;
            word_next = load.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lead_reg <= lead_next;
        trail_reg <= trail_next;
        count_reg <= count_next;
        word_reg <= word_next;
    end

    assign result.valid = pend_valid_reg;
    assign result.out_byte = cur_byte;
    assign result.is_carry = cur_carry;
    assign result.last = cur_last;

endmodule

// ===== rtl/core/static_model_range_encoder_top.sv =====
// Top level of the static-model range encoder.
// An accepted item reads its two cumulative-table entries from the table RAM at the
// accept edge for one coder stage (a 64x15 and a 64x16 multiplier, the 64-bit add and
// the renormalize compare), which updates low and range and hands any results to the
// sequencer. Items with no result (table loads, escape bytes, encodes without
// renormalization) are taken one per cycle unless an item with results holds the
// coder stage until the sequencer is free. The sequencer sends one result per cycle
// unless result.ready is low: four at most for an encode, nine at most for a flush.
// The table has no reset and must be loaded before it is used. Configuration writes
// are taken in any cycle, restart the coder and leave the table as it is.
module static_model_range_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    smre_cfg_if.sink    cfg,
    smre_in_if.sink     item,
    smre_out_if.source  result
);

    localparam int PROD_LO_W = smre_pkg::CODER_W + smre_pkg::TABLE_W;
    localparam int DIFF_W = smre_pkg::TABLE_W + 1;
    localparam int PROD_W_W = smre_pkg::CODER_W + DIFF_W;
    localparam int CW = smre_pkg::CODER_W;
    localparam int BW = smre_pkg::BYTE_W;

    // Coder state and configuration registers.
    logic [smre_pkg::INIT_LOW_W-1:0] init_low_reg, init_low_next;
    logic [CW-1:0]                   init_range_reg, init_range_next;
    logic [CW-1:0]                   low_reg, low_next;
    logic [CW-1:0]                   range_reg, range_next;
    logic [CW-1:0]                   last_low_reg, last_low_next;
    logic                            esc_reg, esc_next;

    // Coder stage.
    logic                            b_valid_reg, b_valid_next;
    logic                            b_flush_reg, b_flush_next;
    logic                            b_advance;
    logic                            has_res;

    logic                            item_fire;
    logic                            cfg_fire;
    logic                            rd_en;
    logic                            tbl_we;
    logic                            b_enter;
    logic                            b_enter_flush;
    logic                            esc_front;
    logic [smre_pkg::SYM_W-1:0]      sym;
    logic [smre_pkg::SYM_W-1:0]      sym_up;

    logic [smre_pkg::TABLE_W-1:0]    lo_b;
    logic [smre_pkg::TABLE_W-1:0]    hi_b;
    logic [DIFF_W-1:0]               width_diff;
    logic [PROD_LO_W-1:0]            lo_prod;
    logic [PROD_W_W-1:0]             width_prod;
    logic [CW-1:0]                   range_w;
    logic [CW-1:0]                   range_nxt;
    logic [CW-1:0]                   low_add;
    logic                            renorm;
    logic                            carry_enc;

    logic [CW-1:0]                   flush_span;
    logic [CW-1:0]                   flush_hi;
    logic [CW-1:0]                   flush_diff;
    logic                            flush_ok;
    logic                            carry_flush;
    logic [smre_pkg::CNT_W-1:0]      lead_zero;
    logic                            found;

    logic [CW-1:0]                   restart_low;
    logic [CW-1:0]                   restart_range;

    smre_pkg::emit_load_t            emit_load;
    logic                            emit_free;

    assign item_fire = item.valid && item.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    // Front end: table writes, escape tracking and table reads at the accept edge.
    always_comb
    begin
        rd_en = 1'b0;
        tbl_we = 1'b0;
        b_enter = 1'b0;
        b_enter_flush = 1'b0;
        esc_front = esc_reg;
        sym = {1'b0, item.data_byte};
        if (item_fire)
        begin
            case (item.command)
                smre_pkg::CMD_LOAD:
                begin
                    tbl_we = (item.table_index < smre_pkg::SYM_W'(smre_pkg::TABLE_DEPTH));
                end
                smre_pkg::CMD_ENCODE:
                begin
                    if (esc_reg)
                    begin
                        esc_front = 1'b0;
                        sym = {1'b0, item.data_byte} + smre_pkg::SYM_W'(1);
                        rd_en = 1'b1;
                        b_enter = 1'b1;
                    end
                    else if (item.data_byte == smre_pkg::ESCAPE_BYTE)
                    begin
                        esc_front = 1'b1;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        b_enter = 1'b1;
                    end
                end
                smre_pkg::CMD_FLUSH:
                begin
                    esc_front = 1'b0;
                    b_enter = 1'b1;
                    b_enter_flush = 1'b1;
                end
                default:
                begin
                    esc_front = esc_reg;
                end
            endcase
        end
    end

    assign sym_up = sym + smre_pkg::SYM_W'(1);

    smre_ram #(
        .WIDTH (smre_pkg::TABLE_W),
        .DEPTH (smre_pkg::TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .we        (tbl_we),
        .wr_addr   (item.table_index),
        .wr_data   (item.table_value),
        .re        (rd_en),
        .rd_addr_a (sym),
        .rd_addr_b (sym_up),
        .rd_data_a (lo_b),
        .rd_data_b (hi_b)
    );

    // Encode arithmetic. A descending table gives a negative width, which the
    // product takes as a sign-extended multiplier modulo 2^64.
    assign width_diff = {1'b0, hi_b} - {1'b0, lo_b};
    assign lo_prod = PROD_LO_W'(range_reg) * PROD_LO_W'(lo_b);
    assign width_prod = PROD_W_W'(range_reg) * PROD_W_W'(width_diff);
    assign range_w = width_prod[CW-1:0]
        - (width_diff[DIFF_W-1] ? {range_reg[CW-DIFF_W-1:0], DIFF_W'(0)} : CW'(0));
    assign range_nxt = range_w >> smre_pkg::RANGE_PRECISION;
    assign renorm = (range_nxt <= smre_pkg::RENORM_LIMIT);
    assign low_add = low_reg + lo_prod[CW-1:0];
    assign carry_enc = (low_add < last_low_reg);

    // Flush arithmetic.
    assign flush_span = (range_reg << smre_pkg::RANGE_PRECISION) - CW'(1);
    assign flush_hi = low_reg + flush_span;
    assign flush_ok = (flush_hi > low_reg);
    assign flush_diff = low_reg ^ flush_hi;
    assign carry_flush = (low_reg < last_low_reg);

    // Number of top bytes that low and high share.
    always_comb
    begin
        lead_zero = '0;
        found = 1'b0;
        for (int i = 0; i < smre_pkg::FLUSH_SCAN_BYTES; i++)
        begin
            if (!found)
            begin
                if (flush_diff[CW-1-BW*i -: BW] == '0)
                begin
                    lead_zero = lead_zero + smre_pkg::CNT_W'(1);
                end
                else
                begin
                    found = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (b_flush_reg)
        begin
            emit_load.lead_carry = carry_flush;
            emit_load.trail_carry = !flush_ok;
            emit_load.byte_count = flush_ok ? lead_zero + smre_pkg::CNT_W'(1) : '0;
            emit_load.word = flush_hi;
        end
        else
        begin
            emit_load.lead_carry = carry_enc;
            emit_load.trail_carry = 1'b0;
            emit_load.byte_count = smre_pkg::CNT_W'(smre_pkg::RENORM_BYTES);
            emit_load.word = low_add;
        end
    end

    assign has_res = b_flush_reg || renorm;
    assign b_advance = b_valid_reg && (!has_res || emit_free);
    assign item.ready = !b_valid_reg || b_advance;

    smre_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (b_valid_reg && has_res),
        .load       (emit_load),
        .free       (emit_free),
        .result     (result)
    );

    // State update: configuration writes, coder stage and escape tracking.
    always_comb
    begin
        init_low_next = init_low_reg;
        init_range_next = init_range_reg;
        if (cfg_fire)
        begin
            case (cfg.index)
                smre_pkg::REG_INITIAL_LOW:
                begin
                    init_low_next = cfg.data[smre_pkg::INIT_LOW_W-1:0];
                end
                smre_pkg::REG_INITIAL_RANGE:
                begin
                    init_range_next = cfg.data;
                end
                default:
                begin
                    init_low_next = init_low_reg;
                end
            endcase
        end
    end

    assign restart_low = {init_low_next, 1'b0};
    assign restart_range = init_range_next >> (smre_pkg::RANGE_PRECISION - 1);

    always_comb
    begin
        low_next = low_reg;
        range_next = range_reg;
        last_low_next = last_low_reg;
        esc_next = esc_front;
        b_flush_next = b_flush_reg;
        b_valid_next = b_valid_reg;
        if (b_advance)
        begin
            b_valid_next = 1'b0;
            if (b_flush_reg)
            begin
                low_next = restart_low;
                range_next = restart_range;
                last_low_next = restart_low;
            end
            else if (renorm)
            begin
                low_next = low_add << smre_pkg::RENORM_SHIFT;
                range_next = range_w << (smre_pkg::RENORM_SHIFT - smre_pkg::RANGE_PRECISION);
                last_low_next = low_add << smre_pkg::RENORM_SHIFT;
            end
            else
            begin
                low_next = low_add;
                range_next = range_nxt;
            end
        end
        if (b_enter)
        begin
            b_valid_next = 1'b1;
            b_flush_next = b_enter_flush;
        end
        if (cfg_fire)
        begin
            low_next = restart_low;
            range_next = restart_range;
            last_low_next = restart_low;
            esc_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_low_reg <= '0;
            init_range_reg <= CW'(1) << (CW - 1);
            low_reg <= '0;
            range_reg <= (CW'(1) << (CW - 1)) >> (smre_pkg::RANGE_PRECISION - 1);
            last_low_reg <= '0;
            esc_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_flush_reg <= 1'b0;
        end
        else
        begin
            init_low_reg <= init_low_next;
            init_range_reg <= init_range_next;
            low_reg <= low_next;
            range_reg <= range_next;
            last_low_reg <= last_low_next;
            esc_reg <= esc_next;
            b_valid_reg <= b_valid_next;
            b_flush_reg <= b_flush_next;
        end
    end

`ifndef SYNTHESIS
    // A stalled coder stage keeps its item.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_advance |=> b_valid_reg && $stable(b_flush_reg))
        else $error("coder stage lost a stalled item");

    // The coder state moves only when an item leaves the coder stage or on a write.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !b_advance && !cfg_fire |=> $stable(low_reg) && $stable(range_reg))
        else $error("coder state changed with no item");

    // A result transfer that is not the last one of its item is followed by more.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last |=> result.valid)
        else $error("result burst ended without last");

    // An encode that does not renormalize has no results and leaves the coder stage at once.
    a_load_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !b_flush_reg && !renorm |-> b_advance)
        else $error("encode without results stalled");
`endif

endmodule
